FILE: src/att_pkg.sv
package att_pkg;

   localparam int ROW_COUNT = 24;
   localparam int COL_COUNT = 80;
   localparam int CELL_COUNT = ROW_COUNT * COL_COUNT;
   localparam int ROW_W = 5;
   localparam int COL_W = 7;
   localparam int ADDR_W = $clog2(CELL_COUNT);

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_ESC   = 8'h1b;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DEL   = 8'h7f;
   localparam logic [7:0] CH_LBRK  = 8'h5b;
   localparam logic [7:0] CH_MARK  = 8'h5f;
   localparam logic [7:0] CH_SEMI  = 8'h3b;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UP    = 8'h41;
   localparam logic [7:0] CH_DOWN  = 8'h42;
   localparam logic [7:0] CH_RIGHT = 8'h43;
   localparam logic [7:0] CH_LEFT  = 8'h44;
   localparam logic [7:0] CH_HOME  = 8'h48;
   localparam logic [7:0] CH_ED    = 8'h4a;
   localparam logic [7:0] CH_EL    = 8'h4b;

   // Classified operation codes passed from front to back
   localparam logic [3:0] OP_READ   = 4'd0;
   localparam logic [3:0] OP_BS     = 4'd1;
   localparam logic [3:0] OP_CR     = 4'd2;
   localparam logic [3:0] OP_LF     = 4'd3;
   localparam logic [3:0] OP_NOP    = 4'd4;  // seq state only, no mark
   localparam logic [3:0] OP_PRINT  = 4'd5;
   localparam logic [3:0] OP_MARK   = 4'd6;  // only redraw mark
   localparam logic [3:0] OP_EL     = 4'd7;
   localparam logic [3:0] OP_ED     = 4'd8;
   localparam logic [3:0] OP_UP     = 4'd9;
   localparam logic [3:0] OP_DOWN   = 4'd10;
   localparam logic [3:0] OP_RIGHT  = 4'd11;
   localparam logic [3:0] OP_LEFT   = 4'd12;
   localparam logic [3:0] OP_HOME   = 4'd13;

   typedef struct packed {
      logic [3:0]       op;
      logic [7:0]       ch;
      logic [7:0]       num;
      logic [7:0]       first;
      logic             in_seq;
      logic [ROW_W-1:0] rrow;
      logic [COL_W-1:0] rcol;
   } cmd_type;

   typedef struct packed {
      logic [7:0]       cell_char;
      logic [ROW_W-1:0] cursor_row;
      logic [COL_W-1:0] cursor_col;
      logic             in_sequence;
   } rsp_type;

   typedef struct packed {
      logic             func;
      logic [7:0]       data_byte;
      logic [ROW_W-1:0] read_row;
      logic [COL_W-1:0] read_col;
   } req_type;

endpackage

FILE: src/att_if.sv
interface att_req_if;
   import att_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface att_rsp_if;
   import att_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface att_cmd_if;
   import att_pkg::*;
   logic    valid;
   logic    ready;
   cmd_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: src/att_front.sv
// Parses escape sequences and classifies each byte into a command.
module att_front (
   input  logic clock,
   input  logic reset,
   att_req_if.sink   req,
   att_cmd_if.source cmd
);
   import att_pkg::*;

   logic       esc_ff, esc_in;
   logic       csi_ff, csi_in;
   logic [7:0] num_ff, num_in;
   logic [7:0] first_ff, first_in;
   cmd_type    c;
   logic [7:0] b;
   logic [11:0] acc;

   assign req.ready = cmd.ready;
   assign cmd.valid = req.valid;
   assign b = req.data.data_byte;
   assign acc = {4'd0, num_ff} * 12'd10 + {8'd0, b[3:0]};

   // Decode: next sequence state and the command for the back end
   always_comb begin
      esc_in = esc_ff;
      csi_in = csi_ff;
      num_in = num_ff;
      first_in = first_ff;
      c.op = OP_MARK;
      c.ch = b;
      c.num = num_ff;
      c.first = first_ff;
      c.rrow = req.data.read_row;
      c.rcol = req.data.read_col;
      if (req.data.func) begin
         c.op = OP_READ;
      end else if (b == CH_BS) begin
         c.op = OP_BS;
      end else if (b == CH_CR) begin
         c.op = OP_CR;
      end else if (b == CH_LF) begin
         c.op = OP_LF;
      end else if (b == CH_ESC) begin
         c.op = OP_NOP;
         esc_in = 1'b1;
      end else if (esc_ff && b == CH_LBRK) begin
         c.op = OP_NOP;
         esc_in = 1'b0;
         csi_in = 1'b1;
      end else if (csi_ff) begin
         esc_in = 1'b0;
         if (b >= CH_0 && b <= CH_9) begin
            c.op = OP_NOP;
            num_in = (acc > 12'd255) ? 8'd255 : acc[7:0];
         end else if (b == CH_SEMI) begin
            c.op = OP_NOP;
            first_in = num_ff;
            num_in = 8'd0;
         end else begin
            unique case (b)
               CH_EL:    c.op = OP_EL;
               CH_ED:    c.op = (num_ff == 8'd2) ? OP_ED : OP_MARK;
               CH_UP:    c.op = OP_UP;
               CH_DOWN:  c.op = OP_DOWN;
               CH_RIGHT: c.op = OP_RIGHT;
               CH_LEFT:  c.op = OP_LEFT;
               CH_HOME:  c.op = OP_HOME;
               default:  c.op = OP_MARK;
            endcase
            csi_in = 1'b0;
            num_in = 8'd0;
            first_in = 8'd0;
         end
      end else begin
         esc_in = 1'b0;
         num_in = 8'd0;
         first_in = 8'd0;
         c.op = (b >= CH_SPACE && b < CH_DEL) ? OP_PRINT : OP_MARK;
      end
      c.in_seq = esc_in | csi_in;
   end

   assign cmd.data = c;

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= 1'b0;
         csi_ff <= 1'b0;
         num_ff <= 8'd0;
         first_ff <= 8'd0;
      end else if (req.valid && cmd.ready && !req.data.func) begin
         esc_ff <= esc_in;
         csi_ff <= csi_in;
         num_ff <= num_in;
         first_ff <= first_in;
      end
   end
endmodule

FILE: src/att_queue.sv
// Two-entry command queue between front and back.
module att_queue (
   input  logic clock,
   input  logic reset,
   att_cmd_if.sink   din,
   att_cmd_if.source dout
);
   import att_pkg::*;

   cmd_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign din.ready = cnt_ff != 2'd2;
   assign dout.valid = cnt_ff != 2'd0;
   assign dout.data = mem_ff[rp_ff];
   assign push = din.valid && din.ready;
   assign pop = dout.valid && dout.ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= din.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

FILE: src/att_back.sv
// Executes commands on the screen store; sweeps for clear and scroll.
module att_back (
   input  logic clock,
   input  logic reset,
   att_cmd_if.sink   cmd,
   att_rsp_if.source rsp
);
   import att_pkg::*;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_EXEC   = 4'd2;
   localparam logic [3:0] S_SCRD   = 4'd3;  // scroll: issue read
   localparam logic [3:0] S_SCWR   = 4'd4;  // scroll: write below-row cell up
   localparam logic [3:0] S_FILL   = 4'd5;  // blank cells from addr to end
   localparam logic [3:0] S_MARK   = 4'd6;
   localparam logic [3:0] S_RDWAIT = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;

   logic [7:0]        store [CELL_COUNT];
   logic [7:0]        rdata_ff;
   logic [3:0]        st_ff, st_in;
   cmd_type           c_ff, c_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [ADDR_W-1:0] end_ff, end_in;
   logic              mark_ff, mark_in;
   logic              rsp_v_ff, rsp_v_in;
   rsp_type           rsp_ff, rsp_in;
   logic              we;
   logic [ADDR_W-1:0] waddr, raddr;
   logic [7:0]        wdata;
   logic [ADDR_W-1:0] cur_addr;
   logic [ROW_W:0]    row_p;
   logic [COL_W:0]    col_p;
   logic [8:0]        rsum;
   logic [8:0]        csum;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] LAST_ROW_ADDR = ADDR_W'((ROW_COUNT - 1) * COL_COUNT);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROW_COUNT - 1);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COL_COUNT - 1);

   assign cur_addr = ADDR_W'(row_ff * COL_COUNT) + ADDR_W'(col_ff);
   assign cmd.ready = (st_ff == S_IDLE);
   assign rsp.valid = rsp_v_ff;
   assign rsp.data = rsp_ff;
   assign rsum = {4'd0, row_ff} + {1'b0, c_ff.num};
   assign csum = {2'd0, col_ff} + {1'b0, c_ff.num};

   // Control and cursor sequencing
   always_comb begin
      st_in = st_ff;
      c_in = c_ff;
      row_in = row_ff;
      col_in = col_ff;
      ptr_in = ptr_ff;
      end_in = end_ff;
      mark_in = mark_ff;
      rsp_v_in = rsp_v_ff;
      rsp_in = rsp_ff;
      we = 1'b0;
      waddr = cur_addr;
      wdata = CH_SPACE;
      raddr = ptr_ff;
      row_p = {1'b0, row_ff};
      col_p = {1'b0, col_ff};
      if (rsp.ready) rsp_v_in = 1'b0;
      unique case (st_ff)
         S_CLEAR: begin
            we = 1'b1;
            waddr = ptr_ff;
            ptr_in = ptr_ff + ADDR_W'(1);
            if (ptr_ff == end_ff) st_in = mark_ff ? S_MARK : S_IDLE;
         end
         S_IDLE: begin
            if (cmd.valid && cmd.ready) begin
               c_in = cmd.data;
               ptr_in = ADDR_W'(cmd.data.rrow * COL_COUNT) + ADDR_W'(cmd.data.rcol);
               st_in = (cmd.data.op == OP_READ) ? S_RDWAIT : S_EXEC;
            end
         end
         S_RDWAIT: st_in = S_OUT;
         S_EXEC: begin
            mark_in = 1'b1;
            st_in = S_MARK;
            unique case (c_ff.op)
               OP_BS: begin
                  we = 1'b1;
                  if (col_ff == '0) begin
                     if (row_ff != '0) begin
                        row_in = row_ff - ROW_W'(1);
                        col_in = LAST_COL;
                     end
                  end else col_in = col_ff - COL_W'(1);
               end
               OP_CR: begin
                  we = 1'b1;
                  col_in = '0;
                  mark_in = 1'b0;
                  st_in = S_OUT;
               end
               OP_LF: row_p = {1'b0, row_ff} + (ROW_W+1)'(1);
               OP_NOP: begin
                  mark_in = 1'b0;
                  st_in = S_OUT;
               end
               OP_PRINT: begin
                  we = 1'b1;
                  wdata = c_ff.ch;
                  if (col_ff == LAST_COL) begin
                     col_in = '0;
                     row_p = {1'b0, row_ff} + (ROW_W+1)'(1);
                  end else col_in = col_ff + COL_W'(1);
               end
               OP_EL: begin
                  ptr_in = cur_addr;
                  end_in = ADDR_W'(row_ff * COL_COUNT) + ADDR_W'(LAST_COL);
                  st_in = S_FILL;
               end
               OP_ED: begin
                  ptr_in = '0;
                  end_in = LAST_ADDR;
                  row_in = '0;
                  col_in = '0;
                  st_in = S_FILL;
               end
               OP_UP: begin
                  we = 1'b1;
                  row_in = ({3'd0, row_ff} < c_ff.num) ? '0 : row_ff - c_ff.num[ROW_W-1:0];
               end
               OP_DOWN: begin
                  we = 1'b1;
                  row_in = (rsum > {4'd0, LAST_ROW}) ? LAST_ROW : rsum[ROW_W-1:0];
               end
               OP_RIGHT: begin
                  we = 1'b1;
                  col_in = (csum > {2'd0, LAST_COL}) ? LAST_COL : csum[COL_W-1:0];
               end
               OP_LEFT: begin
                  we = 1'b1;
                  col_in = ({1'b0, col_ff} < c_ff.num) ? '0 : col_ff - c_ff.num[COL_W-1:0];
               end
               OP_HOME: begin
                  we = 1'b1;
                  row_in = (c_ff.first > {3'd0, LAST_ROW}) ? LAST_ROW : c_ff.first[ROW_W-1:0];
                  col_in = (c_ff.num > {1'b0, LAST_COL}) ? LAST_COL : c_ff.num[COL_W-1:0];
               end
               default: ;
            endcase
            if (c_ff.op == OP_LF || c_ff.op == OP_PRINT) begin
               if (row_p >= (ROW_W+1)'(ROW_COUNT)) begin
                  row_in = LAST_ROW;
                  ptr_in = ADDR_W'(COL_COUNT);
                  st_in = S_SCRD;
               end else row_in = row_p[ROW_W-1:0];
            end
         end
         S_SCRD: begin
            raddr = ptr_ff;
            st_in = S_SCWR;
         end
         S_SCWR: begin
            we = 1'b1;
            waddr = ptr_ff - ADDR_W'(COL_COUNT);
            wdata = rdata_ff;
            ptr_in = ptr_ff + ADDR_W'(1);
            if (ptr_ff == LAST_ADDR) begin
               ptr_in = LAST_ROW_ADDR;
               end_in = LAST_ADDR;
               st_in = S_FILL;
            end else st_in = S_SCRD;
         end
         S_FILL: begin
            we = 1'b1;
            waddr = ptr_ff;
            ptr_in = ptr_ff + ADDR_W'(1);
            if (ptr_ff == end_ff) st_in = S_MARK;
         end
         S_MARK: begin
            we = 1'b1;
            wdata = CH_MARK;
            st_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_v_ff || rsp.ready) begin
               rsp_v_in = 1'b1;
               rsp_in.cell_char = 8'd0;
               if (c_ff.op == OP_READ && c_ff.rrow < ROW_W'(ROW_COUNT)
                   && c_ff.rcol < COL_W'(COL_COUNT)) rsp_in.cell_char = rdata_ff;
               rsp_in.cursor_row = row_ff;
               rsp_in.cursor_col = col_ff;
               rsp_in.in_sequence = c_ff.in_seq;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   // Screen store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) store[waddr] <= wdata;
      rdata_ff <= store[raddr];
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         st_ff <= S_CLEAR;
         row_ff <= '0;
         col_ff <= '0;
         ptr_ff <= '0;
         end_ff <= LAST_ADDR;
         mark_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         row_ff <= row_in;
         col_ff <= col_in;
         ptr_ff <= ptr_in;
         end_ff <= end_in;
         mark_ff <= mark_in;
         rsp_v_ff <= rsp_v_in;
      end
   end
endmodule

FILE: src/ansi_text_terminal.sv
// Channel  Dir  Payload                                          Handshake
// req      in   func, data_byte, read_row, read_col              req_valid / req_ready
// rsp      out  cell_char, cursor_row, cursor_col, in_sequence   rsp_valid / rsp_ready
//
// The back end does one store access per cycle. Scroll copies each cell up a row and
// blanks the last row; erase line blanks to row end, clear screen blanks all cells.
// After reset a clearing pass blanks the store; no byte is executed meanwhile.
// Escape parsing runs ahead through a two-entry queue; rsp stalls hold the back end.
module ansi_text_terminal (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_func,
   input  logic [7:0]             req_data_byte,
   input  logic [4:0]             req_read_row,
   input  logic [6:0]             req_read_col,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_cell_char,
   output logic [4:0]             rsp_cursor_row,
   output logic [6:0]             rsp_cursor_col,
   output logic                   rsp_in_sequence
);
   import att_pkg::*;

   att_req_if req_ch ();
   att_cmd_if cmd_a ();
   att_cmd_if cmd_b ();
   att_rsp_if rsp_ch ();

   assign req_ch.valid = req_valid;
   assign req_ch.data.func = req_func;
   assign req_ch.data.data_byte = req_data_byte;
   assign req_ch.data.read_row = req_read_row;
   assign req_ch.data.read_col = req_read_col;
   assign req_ready = req_ch.ready;

   assign rsp_valid = rsp_ch.valid;
   assign rsp_ch.ready = rsp_ready;
   assign rsp_cell_char = rsp_ch.data.cell_char;
   assign rsp_cursor_row = rsp_ch.data.cursor_row;
   assign rsp_cursor_col = rsp_ch.data.cursor_col;
   assign rsp_in_sequence = rsp_ch.data.in_sequence;

   att_front u_front (.clock(clock), .reset(reset), .req(req_ch.sink), .cmd(cmd_a.source));
   att_queue u_queue (.clock(clock), .reset(reset), .din(cmd_a.sink), .dout(cmd_b.source));
   att_back  u_back  (.clock(clock), .reset(reset), .cmd(cmd_b.sink), .rsp(rsp_ch.source));
endmodule
